// File: hdl/nearest_centroid_search_defines.svh
// Assertion macros shared by the nearest centroid search RTL.
`ifndef NEAREST_CENTROID_SEARCH_DEFINES_SVH
`define NEAREST_CENTROID_SEARCH_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define NCS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("nearest_centroid_search: check failed");

// Check that a condition in one cycle implies another in the next.
`define NCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nearest_centroid_search: sequence check failed");

`endif

// File: hdl/ncs_pkg.sv
// Shared widths, codes and types of the nearest centroid search.
package ncs_pkg;

  localparam int SlotW = 4;
  localparam int DimW  = 7;
  localparam int ValW  = 16;
  localparam int QvalW = 8;
  localparam int SqW   = 32;
  localparam int AccW  = 40;
  localparam int OutW  = 39;
  localparam int IdxW  = 4;

  localparam logic ACTION_LOAD  = 1'b0;
  localparam logic ACTION_QUERY = 1'b1;

  typedef struct packed {
    logic is_query;
    logic dim_zero;
    logic dim_last;
  } ncs_flags_t;

  typedef struct packed {
    logic busy;
    logic take;
  } ncs_back_status_t;

endpackage

// File: hdl/ncs_fifo.sv
// Small register queue between the front and back parts.
module ncs_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [Width-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output logic [Width-1:0] rd_data_o,
  output logic             valid_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_wr && do_rd) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// File: hdl/ncs_front.sv
// Front part: classifies input beats, drops out-of-range ones, forms store addresses.
module ncs_front
  import ncs_pkg::*;
#(
  parameter int NUM_CENTERS = 10,
  parameter int DIMS        = 128,
  parameter int AddrW       = 11
) (
  input  logic             accept_i,
  input  logic             action_i,
  input  logic [SlotW-1:0] slot_i,
  input  logic [DimW-1:0]  dim_i,
  input  logic [ValW-1:0]  center_value_i,
  input  logic [QvalW-1:0] query_value_i,
  output logic             keep_o,
  output ncs_flags_t       flags_o,
  output logic [ValW-1:0]  value_o,
  output logic [AddrW-1:0] addr_o
);

  logic slot_ok, dim_ok;

  assign slot_ok = (32'(slot_i) < NUM_CENTERS);
  assign dim_ok  = (32'(dim_i) < DIMS);

  always_comb begin
    flags_o.is_query = (action_i == ACTION_QUERY);
    flags_o.dim_zero = (dim_i == '0);
    flags_o.dim_last = (32'(dim_i) == DIMS - 1);
    if (action_i == ACTION_QUERY) begin
      // a query starts at centroid zero, whose element sits at address dim
      keep_o  = accept_i && dim_ok;
      value_o = {query_value_i, (ValW - QvalW)'(0)};
      addr_o  = AddrW'(dim_i);
    end else begin
      keep_o  = accept_i && dim_ok && slot_ok;
      value_o = center_value_i;
      addr_o  = AddrW'(slot_i) * AddrW'(DIMS) + AddrW'(dim_i);
    end
  end

endmodule

// File: hdl/ncs_back.sv
// Back part: centroid store, shared squarer, running distances and minimum search.
module ncs_back
  import ncs_pkg::*;
#(
  parameter int NUM_CENTERS = 10,
  parameter int DIMS        = 128,
  parameter int AddrW       = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  ncs_flags_t       flags_i,
  input  logic [ValW-1:0]  value_i,
  input  logic [AddrW-1:0] addr_i,
  output ncs_back_status_t status_o,
  output logic             out_valid_o,
  input  logic             pop_i,
  output logic [IdxW-1:0]  nearest_o,
  output logic [OutW-1:0]  min_distance_o
);

  localparam int CntW  = $clog2(NUM_CENTERS);
  localparam int Depth = NUM_CENTERS * DIMS;

  logic [ValW-1:0]  store_q [Depth];
  logic [AccW-1:0]  acc_q [NUM_CENTERS];

  logic             run_q;
  logic [CntW-1:0]  cnt_q;
  logic [AddrW-1:0] rd_addr_q;
  logic [ValW-1:0]  qv_q;
  logic             dim_zero_q, dim_last_q;

  logic             s1_valid_q, s2_valid_q;
  logic [CntW-1:0]  s1_idx_q, s2_idx_q;
  logic [ValW-1:0]  rd_q;
  logic [SqW-1:0]   sq_q, sq_d;
  logic [ValW-1:0]  diff;

  logic [AccW-1:0]  best_q, best_d;
  logic [CntW-1:0]  best_idx_q, best_idx_d;
  logic [AccW-1:0]  base, acc_new;
  logic [AccW:0]    sum;
  logic             better, finish;

  logic             out_valid_q;
  logic [IdxW-1:0]  nearest_q;
  logic [OutW-1:0]  min_q;

  logic             busy, take, do_load;

  assign busy = run_q || s1_valid_q || s2_valid_q;
  // hold a last-dimension byte until the previous result is taken
  assign take = valid_i && !busy && !(flags_i.is_query && flags_i.dim_last && out_valid_q);
  assign do_load = take && !flags_i.is_query;

  assign status_o.busy = busy;
  assign status_o.take = take;

  // single store: loads write, queries read one centroid element per cycle
  always_ff @(posedge clk_i) begin
    if (do_load) begin
      store_q[addr_i] <= value_i;
    end
    rd_q <= store_q[rd_addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q      <= 1'b0;
      cnt_q      <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= run_q;
      s2_valid_q <= s1_valid_q;
      if (take && flags_i.is_query) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(NUM_CENTERS - 1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && flags_i.is_query) begin
      rd_addr_q  <= addr_i;
      qv_q       <= value_i;
      dim_zero_q <= flags_i.dim_zero;
      dim_last_q <= flags_i.dim_last;
    end else if (run_q) begin
      // advance to the same dimension of the next centroid
      rd_addr_q <= rd_addr_q + AddrW'(DIMS);
    end
    s1_idx_q <= cnt_q;
    s2_idx_q <= s1_idx_q;
    sq_q     <= sq_d;
  end

  assign diff = (qv_q >= rd_q) ? (qv_q - rd_q) : (rd_q - qv_q);
  assign sq_d = SqW'(diff) * SqW'(diff);

  always_comb begin
    base    = dim_zero_q ? '0 : acc_q[s2_idx_q];
    sum     = (AccW + 1)'(base) + (AccW + 1)'(sq_q);
    acc_new = sum[AccW] ? {AccW{1'b1}} : sum[AccW-1:0];
    // strict compare keeps the lower index on ties
    better  = (s2_idx_q == '0) || (acc_new < best_q);
    best_d     = better ? acc_new : best_q;
    best_idx_d = better ? s2_idx_q : best_idx_q;
    finish  = s2_valid_q && dim_last_q && (s2_idx_q == CntW'(NUM_CENTERS - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CENTERS; i++) begin
        acc_q[i] <= '0;
      end
    end else if (s2_valid_q) begin
      acc_q[s2_idx_q] <= acc_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && dim_last_q) begin
      best_q     <= best_d;
      best_idx_q <= best_idx_d;
    end
    if (finish) begin
      nearest_q <= IdxW'(best_idx_d);
      min_q     <= best_d[AccW-1] ? {OutW{1'b1}} : best_d[OutW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign nearest_o      = nearest_q;
  assign min_distance_o = min_q;

endmodule

// File: hdl/nearest_centroid_search.sv
// Top level of the nearest centroid search: front, queue and back wired together.
//
//   channel   direction  handshake          fields
//   items     in         push / full        action, slot, dim, center_value, query_value
//   results   out        empty / pop        nearest, min_distance
//
// A centroid load is a single store write in the back part; a query byte reads the
// store once per centroid through the single read port, then the squarer and the
// accumulate stage drain before the back takes another beat.
// Reset clears the running distances and all control; the centroid store is not cleared.
// The front accepts beats while the two-entry queue has room; the back holds a
// last-dimension byte while the previous result still waits to be popped.
`include "nearest_centroid_search_defines.svh"

module nearest_centroid_search
  import ncs_pkg::*;
#(
  parameter int NUM_CENTERS = 10,
  parameter int DIMS        = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic             action_i,
  input  logic [SlotW-1:0] slot_i,
  input  logic [DimW-1:0]  dim_i,
  input  logic [ValW-1:0]  center_value_i,
  input  logic [QvalW-1:0] query_value_i,
  output logic             empty,
  input  logic             pop,
  output logic [IdxW-1:0]  nearest_o,
  output logic [OutW-1:0]  min_distance_o
);

  localparam int AddrW  = $clog2(NUM_CENTERS * DIMS);
  localparam int FlagW  = $bits(ncs_flags_t);
  localparam int EntryW = FlagW + ValW + AddrW;

  logic             keep;
  ncs_flags_t       fr_flags, bk_flags;
  logic [ValW-1:0]  fr_value, bk_value;
  logic [AddrW-1:0] fr_addr, bk_addr;
  logic [EntryW-1:0] q_rd_data;
  logic             q_valid;
  logic             out_valid;
  ncs_back_status_t status;

  ncs_front #(
    .NUM_CENTERS(NUM_CENTERS),
    .DIMS       (DIMS),
    .AddrW      (AddrW)
  ) u_front (
    .accept_i      (push && !full),
    .action_i      (action_i),
    .slot_i        (slot_i),
    .dim_i         (dim_i),
    .center_value_i(center_value_i),
    .query_value_i (query_value_i),
    .keep_o        (keep),
    .flags_o       (fr_flags),
    .value_o       (fr_value),
    .addr_o        (fr_addr)
  );

  ncs_fifo #(
    .Width(EntryW),
    .Depth(2)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (keep),
    .wr_data_i({fr_flags, fr_value, fr_addr}),
    .full_o   (full),
    .rd_en_i  (status.take),
    .rd_data_o(q_rd_data),
    .valid_o  (q_valid)
  );

  assign bk_flags = ncs_flags_t'(q_rd_data[EntryW-1 -: FlagW]);
  assign bk_value = q_rd_data[AddrW +: ValW];
  assign bk_addr  = q_rd_data[AddrW-1:0];

  ncs_back #(
    .NUM_CENTERS(NUM_CENTERS),
    .DIMS       (DIMS),
    .AddrW      (AddrW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .flags_i       (bk_flags),
    .value_i       (bk_value),
    .addr_i        (bk_addr),
    .status_o      (status),
    .out_valid_o   (out_valid),
    .pop_i         (pop),
    .nearest_o     (nearest_o),
    .min_distance_o(min_distance_o)
  );

  assign empty = !out_valid;

  `NCS_ASSERT(a_take_needs_entry, status.take |-> q_valid)
  `NCS_ASSERT(a_result_from_work, $fell(empty) |-> $past(status.busy))
  `NCS_ASSERT(a_nearest_in_range, !empty |-> (32'(nearest_o) < NUM_CENTERS))
  `NCS_ASSERT_NEXT(a_take_starts_work, status.take && bk_flags.is_query, status.busy)

endmodule

// File: tb/tb.sv
// Self-checking testbench for the nearest centroid search block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ncs_pkg::*;

  localparam int NCENT       = 10;
  localparam int NDIM        = 128;
  localparam int LAST_DIM    = NDIM - 1;
  localparam int LOW_DIMS    = 24;
  localparam int ITEMS       = 700;
  localparam int IDLE_PCT    = 37;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE      = 64;
  localparam logic [AccW-1:0] ACC_MAX = {AccW{1'b1}};
  localparam logic [OutW-1:0] OUT_MAX = {OutW{1'b1}};

  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [OutW-1:0] distance;
  } match_t;

  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             push           = 1'b0;
  logic             full;
  logic             action_i       = ACTION_LOAD;
  logic [SlotW-1:0] slot_i         = '0;
  logic [DimW-1:0]  dim_i          = '0;
  logic [ValW-1:0]  center_value_i = '0;
  logic [QvalW-1:0] query_value_i  = '0;
  logic             empty;
  logic             pop            = 1'b0;
  logic [IdxW-1:0]  nearest_o;
  logic [OutW-1:0]  min_distance_o;

  // predictor state
  logic [ValW-1:0]  centroid_copy [NCENT][NDIM];
  logic [AccW-1:0]  running_dist [NCENT];
  logic [QvalW-1:0] tie_bytes [NDIM];
  match_t           pending_matches [$];

  int          beats_taken       = 0;
  int          fail_count        = 0;
  int unsigned cycle_count       = 0;
  bit          steady            = 1'b0;

  nearest_centroid_search #(
    .NUM_CENTERS(NCENT),
    .DIMS       (NDIM)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .action_i      (action_i),
    .slot_i        (slot_i),
    .dim_i         (dim_i),
    .center_value_i(center_value_i),
    .query_value_i (query_value_i),
    .empty         (empty),
    .pop           (pop),
    .nearest_o     (nearest_o),
    .min_distance_o(min_distance_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[nearest_centroid_search] ERROR");
      $finish;
    end
  end

  initial begin
    for (int c = 0; c < NCENT; c++) begin
      running_dist[c] = '0;
      for (int d = 0; d < NDIM; d++) centroid_copy[c][d] = '0;
    end
  end

  // Dimensions below LOW_DIMS map to themselves, the rest to the last one; test_load_centroids loads only these.
  function automatic logic [DimW-1:0] loaded_dim(input int k);
    return (k >= LOW_DIMS) ? DimW'(LAST_DIM) : DimW'(k);
  endfunction

  // Apply one accepted beat to the quantizer copy and queue any result it yields.
  task automatic step_quantizer(input logic act, input logic [SlotW-1:0] slot,
                                input logic [DimW-1:0] dim, input logic [ValW-1:0] cval,
                                input logic [QvalW-1:0] qval);
    logic [ValW-1:0] qfix;
    logic [ValW-1:0] diff;
    logic [AccW:0]   sum;
    logic [AccW-1:0] best;
    int              best_idx;
    match_t          m;
    if (act == ACTION_LOAD) begin
      if (slot < NCENT && dim < NDIM) centroid_copy[slot][dim] = cval;
    end else if (dim < NDIM) begin
      qfix = {qval, 8'h00};
      for (int c = 0; c < NCENT; c++) begin
        diff = (qfix >= centroid_copy[c][dim]) ? qfix - centroid_copy[c][dim]
                                               : centroid_copy[c][dim] - qfix;
        sum = ((dim == 0) ? '0 : {1'b0, running_dist[c]}) + diff * diff;
        running_dist[c] = (sum > ACC_MAX) ? ACC_MAX : sum[AccW-1:0];
      end
      if (dim == LAST_DIM) begin
        best     = running_dist[0];
        best_idx = 0;
        for (int c = 1; c < NCENT; c++) begin
          if (running_dist[c] < best) begin
            best     = running_dist[c];
            best_idx = c;
          end
        end
        m.idx      = best_idx[IdxW-1:0];
        m.distance = (best > OUT_MAX) ? OUT_MAX : best[OutW-1:0];
        pending_matches.push_back(m);
      end
    end
  endtask

  // Offer one beat, idling at random beforehand; returns at the edge that takes it.
  task automatic send_beat(input logic act, input logic [SlotW-1:0] slot,
                           input logic [DimW-1:0] dim, input logic [ValW-1:0] cval,
                           input logic [QvalW-1:0] qval);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push           <= 1'b1;
    action_i       <= act;
    slot_i         <= slot;
    dim_i          <= dim;
    center_value_i <= cval;
    query_value_i  <= qval;
    do @(posedge clk_i); while (full);
    step_quantizer(act, slot, dim, cval, qval);
    beats_taken++;
  endtask

  // Stop sending and hold until every predicted result has been popped.
  task automatic wait_for_matches();
    push <= 1'b0;
    do @(posedge clk_i); while (pending_matches.size() != 0);
  endtask

  task automatic send_vector(input int last, input int mode);
    int s;
    int v;
    logic [DimW-1:0] dim;
    s = $urandom_range(NCENT - 1);
    for (int d = 0; d <= last; d++) begin
      dim = loaded_dim(d);
      case (mode)
        0:       v = $urandom_range(255);
        1, 2:    v = int'(centroid_copy[s][dim][15:8]) + int'($urandom_range(6)) - 3;
        default: v = $urandom_range(1) ? 255 : 0;
      endcase
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      send_beat(ACTION_QUERY, SlotW'($urandom), dim, ValW'($urandom), v[7:0]);
    end
  endtask

  // Slot 0 all zero, slot 9 all ones, slots 3 and 4 identical whole bytes.
  task automatic test_load_centroids();
    logic [ValW-1:0] v;
    logic [DimW-1:0] d;
    for (int i = 0; i < NDIM; i++) tie_bytes[i] = QvalW'($urandom_range(255, 1));
    for (int s = 0; s < NCENT; s++) begin
      for (int k = 0; k <= LOW_DIMS; k++) begin
        d = loaded_dim(k);
        case (s)
          0:       v = '0;
          9:       v = '1;
          3, 4:    v = {tie_bytes[d], 8'h00};
          default: v = ValW'($urandom);
        endcase
        send_beat(ACTION_LOAD, s[SlotW-1:0], d, v, QvalW'($urandom));
      end
    end
  endtask

  // Last dimension alone adds onto the distances left by reset.
  task automatic test_reset_distances();
    send_beat(ACTION_QUERY, 4'hF, DimW'(LAST_DIM), 16'hFFFF, 8'hFF);
  endtask

  task automatic test_extremes();
    send_beat(ACTION_QUERY, '0, '0, '0, 8'h00);
    send_beat(ACTION_QUERY, '0, DimW'(LAST_DIM), '0, 8'h00);
    send_beat(ACTION_QUERY, 4'hF, '0, 16'hFFFF, 8'hFF);
    send_beat(ACTION_QUERY, 4'hF, DimW'(LAST_DIM), 16'hFFFF, 8'hFF);
  endtask

  // Slots 3 and 4 both hit zero distance; the lower one must win.
  task automatic test_tie();
    send_beat(ACTION_QUERY, 4'd4, '0, 16'h5A5A, tie_bytes[0]);
    send_beat(ACTION_QUERY, 4'd4, DimW'(LAST_DIM), 16'hA5A5, tie_bytes[LAST_DIM]);
  endtask

  // Loads to slots past the last centroid must leave the store alone.
  task automatic test_ignored_loads();
    for (int s = NCENT; s < 16; s++)
      send_beat(ACTION_LOAD, s[SlotW-1:0], (s % 2) ? DimW'(LAST_DIM) : '0,
                (s % 2) ? 16'h0000 : 16'hFFFF, QvalW'($urandom));
    send_beat(ACTION_QUERY, '0, '0, '0, QvalW'($urandom));
    send_beat(ACTION_QUERY, '0, DimW'(LAST_DIM), '0, QvalW'($urandom));
  endtask

  // Bytes are summed as they come; every last-dimension byte reports.
  task automatic test_out_of_order();
    send_beat(ACTION_QUERY, SlotW'($urandom), 7'd5, ValW'($urandom), QvalW'($urandom));
    send_beat(ACTION_QUERY, SlotW'($urandom), DimW'(LAST_DIM), ValW'($urandom),
              QvalW'($urandom));
    send_beat(ACTION_QUERY, SlotW'($urandom), '0, ValW'($urandom), QvalW'($urandom));
    send_beat(ACTION_QUERY, SlotW'($urandom), DimW'(LAST_DIM), ValW'($urandom),
              QvalW'($urandom));
    send_beat(ACTION_QUERY, SlotW'($urandom), 7'd17, ValW'($urandom), QvalW'($urandom));
    send_beat(ACTION_QUERY, SlotW'($urandom), DimW'(LAST_DIM), ValW'($urandom),
              QvalW'($urandom));
  endtask

  task automatic test_random_traffic();
    int kind;
    int n;
    int round;
    logic [ValW-1:0] v;
    round = 0;
    while (beats_taken < ITEMS) begin
      steady = (round >= 10 && round < 16);
      kind   = $urandom_range(99);
      if (kind < 55) begin
        send_vector(LOW_DIMS, $urandom_range(3));
      end else if (kind < 70) begin
        n = $urandom_range(6, 1);
        repeat (n) begin
          case ($urandom_range(3))
            0:       v = '0;
            1:       v = '1;
            default: v = ValW'($urandom);
          endcase
          send_beat(ACTION_LOAD, SlotW'($urandom), DimW'($urandom), v, QvalW'($urandom));
        end
      end else if (kind < 85) begin
        // broken sequence: scattered dimensions, often closed by the last one
        n = $urandom_range(10, 1);
        repeat (n)
          send_beat(ACTION_QUERY, SlotW'($urandom), loaded_dim($urandom_range(LOW_DIMS)),
                    ValW'($urandom), QvalW'($urandom));
        if ($urandom_range(1))
          send_beat(ACTION_QUERY, SlotW'($urandom), DimW'(LAST_DIM), ValW'($urandom),
                    QvalW'($urandom));
      end else begin
        send_vector($urandom_range(LOW_DIMS - 1), $urandom_range(3));
      end
      if (round == 4) wait_for_matches();
      round++;
    end
    steady = 1'b0;
  endtask

  // Check each popped beat against the oldest prediction, then pick the next pop.
  always @(posedge clk_i) begin
    match_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (pending_matches.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: nearest=%0d min_distance=%0d",
                     nearest_o, min_distance_o);
        end else begin
          want = pending_matches.pop_front();
          if (nearest_o !== want.idx || min_distance_o !== want.distance) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: nearest exp %0d got %0d, min_distance exp %0d got %0d",
                       want.idx, nearest_o, want.distance, min_distance_o);
          end
        end
      end
      pop <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_load_centroids();
    test_reset_distances();
    wait_for_matches();
    test_extremes();
    test_tie();
    wait_for_matches();
    test_ignored_loads();
    test_out_of_order();
    wait_for_matches();
    test_random_traffic();
    wait_for_matches();
    repeat (SETTLE) @(posedge clk_i);
    if (fail_count == 0) $display("[nearest_centroid_search] OK");
    else $display("[nearest_centroid_search] ERROR");
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/ncs_pkg.sv
hdl/ncs_fifo.sv
hdl/ncs_front.sv
hdl/ncs_back.sv
hdl/nearest_centroid_search.sv
tb/tb.sv
